[hw/rtl/buddy_block_coalescer_defines.svh]
// ----------------------------------------------------------------------------
// buddy block coalescer assertion macros
// shared concurrent check forms, sampled on clk and masked during rst_n low
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_COALESCER_DEFINES_SVH
`define BUDDY_BLOCK_COALESCER_DEFINES_SVH

// same-cycle implication
`define BBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buddy block coalescer check failed");

// next-cycle implication
`define BBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buddy block coalescer check failed");

`endif

[hw/rtl/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg
// shared types, codes and constants of the buddy block coalescer
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

  // default address space is 2^6 units
  localparam int ADDR_BITS_DEF = 6;

  // fixed field widths of the stream words
  localparam int ORDER_W  = 3;
  localparam int ADDRF_W  = 6;
  localparam int STATUS_W = 2;

  // a listing emits at most this many words
  localparam int MAX_OUT = 64;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  typedef enum logic {
    OP_FREE = 1'b0,
    OP_LIST = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_DUP = 2'd2
  } status_t;

  typedef struct packed {
    status_t              status;
    logic                 entry_valid;
    logic [ORDER_W-1:0]   free_order;
    logic [ADDRF_W-1:0]   free_address;
    logic                 is_last;
  } res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_F_LOOK,
    S_F_LOOK_CHK,
    S_F_BUD,
    S_F_BUD_CHK,
    S_F_DONE,
    S_EMIT,
    S_LIST_RD,
    S_LIST_CHK,
    S_LIST_END
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/bbc_map_ram.sv]
// ----------------------------------------------------------------------------
// bbc_map_ram
// one-bit free map, one entry per possible block of every order, single port
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_map_ram import bbc_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic [ADDR_BITS:0]   ram_addr,
  input  logic                 ram_we,
  input  logic                 ram_wdata,
  output logic                 ram_rdata
);

  localparam int DEPTH = (2 ** (ADDR_BITS + 1)) - 1;

  logic mem [DEPTH];
  logic rdata_r;

  // write first-port semantics not needed: read returns old data
  always_ff @(posedge clk) begin
    if (ram_we) begin
      mem[ram_addr] <= ram_wdata;
    end
    rdata_r <= mem[ram_addr];
  end

  assign ram_rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/bbc_index_unit.sv]
// ----------------------------------------------------------------------------
// bbc_index_unit
// shared shift and add unit: map index, buddy address and scan step
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_index_unit import bbc_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic [$clog2(ADDR_BITS+1)-1:0] k,
  input  logic [ADDR_BITS-1:0]           blk_addr,
  input  logic                           use_buddy,
  output logic [ADDR_BITS:0]             map_idx,
  output logic [ADDR_BITS-1:0]           merged_addr,
  output logic [ADDR_BITS-1:0]           scan_addr,
  output logic                           scan_wrap
);

  localparam int AW = ADDR_BITS;
  localparam int TW = ADDR_BITS + 2;

  logic [TW-1:0] total;
  logic [TW-1:0] base;
  logic [TW-1:0] two_mask;
  logic [AW:0]   bsz;
  logic [AW:0]   addr_x;
  logic [AW:0]   bud_x;
  logic [AW:0]   nxt_x;
  logic          aligned;
  logic [AW-1:0] buddy;
  logic [AW-1:0] sel;

  // block size and pair alignment
  always_comb begin
    bsz      = (AW+1)'(1) << k;
    addr_x   = {1'b0, blk_addr};
    two_mask = (TW'(bsz) << 1) - TW'(1);
    aligned  = ((TW'(blk_addr) & two_mask) == '0);
    bud_x    = aligned ? (addr_x + bsz) : (addr_x - bsz);
    buddy    = bud_x[AW-1:0];
  end

  // level base plus block number within the level
  always_comb begin
    total   = TW'(1) << (AW + 1);
    base    = total - (total >> k);
    sel     = use_buddy ? buddy : blk_addr;
    map_idx = (AW+1)'(base + (TW'(sel) >> k));
  end

  // merged block sits at the lower of the pair
  assign merged_addr = aligned ? blk_addr : buddy;

  // next block of the same order during a listing
  assign nxt_x     = addr_x + bsz;
  assign scan_addr = nxt_x[AW-1:0];
  assign scan_wrap = nxt_x[AW];

endmodule

`default_nettype wire

[hw/rtl/bbc_ctrl.sv]
// ----------------------------------------------------------------------------
// bbc_ctrl
// sequencer: clearing pass, free with buddy merge steps, sorted map listing
// ----------------------------------------------------------------------------
`default_nettype none

`include "buddy_block_coalescer_defines.svh"

module bbc_ctrl import bbc_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  opcode_t                        in_op,
  input  logic [ORDER_W-1:0]             in_order,
  input  logic [ADDRF_W-1:0]             in_addr,
  output logic                           res_valid,
  output res_t                           res,
  input  logic                           res_ready,
  output logic [$clog2(ADDR_BITS+1)-1:0] k,
  output logic [ADDR_BITS-1:0]           blk_addr,
  output logic                           use_buddy,
  input  logic [ADDR_BITS:0]             map_idx,
  input  logic [ADDR_BITS-1:0]           merged_addr,
  input  logic [ADDR_BITS-1:0]           scan_addr,
  input  logic                           scan_wrap,
  output logic [ADDR_BITS:0]             ram_addr,
  output logic                           ram_we,
  output logic                           ram_wdata,
  input  logic                           ram_rdata
);

  localparam int AW    = ADDR_BITS;
  localparam int IW    = ADDR_BITS + 1;
  localparam int ORD_W = $clog2(ADDR_BITS + 1);
  localparam int DEPTH = (2 ** (ADDR_BITS + 1)) - 1;
  localparam int CW    = ((ADDR_BITS > ADDRF_W) ? ADDR_BITS : ADDRF_W) + 2;

  state_t             st_r, st_nxt;
  logic [ORD_W-1:0]   k_r, k_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [IW-1:0]      clr_r, clr_nxt;
  status_t            status_r, status_nxt;
  logic [CNT_W-1:0]   found_r, found_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [ORDER_W-1:0] pend_ord_r, pend_ord_nxt;
  logic [ADDRF_W-1:0] pend_addr_r, pend_addr_nxt;

  logic          k_top;
  logic          bad;
  logic [CW-1:0] in_addr_c;
  logic [CW-1:0] size_c;
  logic [CW-1:0] space_c;

  // range and alignment check of an incoming free
  always_comb begin
    in_addr_c = CW'(in_addr);
    size_c    = CW'(1) << in_order;
    space_c   = CW'(1) << AW;
    bad       = (32'(in_order) > ADDR_BITS) ||
                ((in_addr_c & (size_c - CW'(1))) != '0) ||
                ((in_addr_c + size_c) > space_c);
  end

  assign k_top = (k_r == ORD_W'(ADDR_BITS));

  // next state and datapath
  always_comb begin
    st_nxt        = st_r;
    k_nxt         = k_r;
    addr_nxt      = addr_r;
    clr_nxt       = clr_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    pend_v_nxt    = pend_v_r;
    pend_ord_nxt  = pend_ord_r;
    pend_addr_nxt = pend_addr_r;
    case (st_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IW'(DEPTH - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_LIST) begin
            k_nxt      = '0;
            addr_nxt   = '0;
            found_nxt  = '0;
            pend_v_nxt = 1'b0;
            st_nxt     = S_LIST_RD;
          end else if (bad) begin
            status_nxt = ST_BAD;
            st_nxt     = S_EMIT;
          end else begin
            k_nxt    = ORD_W'(in_order);
            addr_nxt = AW'(in_addr);
            st_nxt   = S_F_LOOK;
          end
        end
      end
      S_F_LOOK: begin
        st_nxt = S_F_LOOK_CHK;
      end
      S_F_LOOK_CHK: begin
        if (ram_rdata) begin
          status_nxt = ST_DUP;
          st_nxt     = S_EMIT;
        end else if (k_top) begin
          st_nxt = S_F_DONE;
        end else begin
          st_nxt = S_F_BUD;
        end
      end
      S_F_BUD: begin
        st_nxt = S_F_BUD_CHK;
      end
      S_F_BUD_CHK: begin
        if (ram_rdata) begin
          k_nxt    = k_r + 1'b1;
          addr_nxt = merged_addr;
          st_nxt   = (k_r == ORD_W'(ADDR_BITS - 1)) ? S_F_DONE : S_F_BUD;
        end else begin
          st_nxt = S_F_DONE;
        end
      end
      S_F_DONE: begin
        status_nxt = ST_OK;
        st_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready) begin
          st_nxt = S_IDLE;
        end
      end
      S_LIST_RD: begin
        st_nxt = S_LIST_CHK;
      end
      S_LIST_CHK: begin
        // hold while the previous block still waits for the output register
        if (!(ram_rdata && pend_v_r && !res_ready)) begin
          if (ram_rdata) begin
            pend_v_nxt    = 1'b1;
            pend_ord_nxt  = ORDER_W'(k_r);
            pend_addr_nxt = ADDRF_W'(addr_r);
            found_nxt     = found_r + 1'b1;
          end
          if (ram_rdata && (found_r == CNT_W'(MAX_OUT - 1))) begin
            st_nxt = S_LIST_END;
          end else if (k_top) begin
            st_nxt = S_LIST_END;
          end else begin
            if (scan_wrap) begin
              k_nxt    = k_r + 1'b1;
              addr_nxt = '0;
            end else begin
              addr_nxt = scan_addr;
            end
            st_nxt = S_LIST_RD;
          end
        end
      end
      S_LIST_END: begin
        if (res_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (st_r == S_IDLE);
    use_buddy = (st_r == S_F_BUD) || (st_r == S_F_BUD_CHK);
    ram_addr  = map_idx;
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    res_valid = 1'b0;
    res       = '{status: ST_OK, entry_valid: 1'b0, free_order: '0,
                  free_address: '0, is_last: 1'b1};
    case (st_r)
      S_CLEAR: begin
        ram_addr = clr_r;
        ram_we   = 1'b1;
      end
      S_F_BUD_CHK: begin
        // buddy absorbed, its own entry goes away
        ram_we = ram_rdata;
      end
      S_F_DONE: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b1;
      end
      S_EMIT: begin
        res_valid = 1'b1;
        res.status = status_r;
        if (status_r == ST_OK) begin
          res.entry_valid  = 1'b1;
          res.free_order   = ORDER_W'(k_r);
          res.free_address = ADDRF_W'(addr_r);
        end
      end
      S_LIST_CHK: begin
        res_valid        = ram_rdata && pend_v_r;
        res.entry_valid  = 1'b1;
        res.free_order   = pend_ord_r;
        res.free_address = pend_addr_r;
        res.is_last      = 1'b0;
      end
      S_LIST_END: begin
        res_valid = 1'b1;
        if (pend_v_r) begin
          res.entry_valid  = 1'b1;
          res.free_order   = pend_ord_r;
          res.free_address = pend_addr_r;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLEAR;
      clr_r    <= '0;
      found_r  <= '0;
      pend_v_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      clr_r    <= clr_nxt;
      found_r  <= found_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    addr_r      <= addr_nxt;
    status_r    <= status_nxt;
    pend_ord_r  <= pend_ord_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

  assign k        = k_r;
  assign blk_addr = addr_r;

  `BBC_ASSERT_NXT(a_accept_busy, in_valid && in_ready, st_r != S_IDLE)
  `BBC_ASSERT_NXT(a_merge_step, (st_r == S_F_BUD_CHK) && ram_rdata, k_r == $past(k_r) + 1'b1)
  `BBC_ASSERT_IMP(a_found_bound, 1'b1, found_r <= CNT_W'(MAX_OUT))
  `BBC_ASSERT_IMP(a_mid_word_in_list, res_valid && !res.is_last, st_r == S_LIST_CHK)
  `BBC_ASSERT_IMP(a_list_no_write, (st_r == S_LIST_RD) || (st_r == S_LIST_CHK), !ram_we)

endmodule

`default_nettype wire

[hw/rtl/buddy_block_coalescer.sv]
// a free reads its own map entry, then merges up one order per free buddy (m merge attempts, <= ADDR_BITS)
// a bad block is answered straight from idle, an already free block once its own entry is read
// a listing reads the free map entry by entry, holding while the output register is full
// one item at a time, the map memory port and its sequencer set the rate
// after reset a clearing pass zeroes all 2^(ADDR_BITS+1)-1 map entries (127 at 6 bits), no word taken
// ----------------------------------------------------------------------------
// buddy_block_coalescer
// buddy-system free block recovery with sorted listing of the free map
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_coalescer import bbc_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // block_order[2:0], block_address[8:3], zero
  input  logic [0:0]  in_tuser,   // opcode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // free_order[2:0], free_address[8:3], zero
  output logic [2:0]  out_tuser,  // status[1:0], entry_valid[2]
  output logic        out_tlast
);

  localparam int ORD_W = $clog2(ADDR_BITS + 1);

  logic               res_valid;
  res_t               res;
  logic               res_ready;
  logic [ORD_W-1:0]   k;
  logic [ADDR_BITS-1:0] blk_addr;
  logic               use_buddy;
  logic [ADDR_BITS:0] map_idx;
  logic [ADDR_BITS-1:0] merged_addr;
  logic [ADDR_BITS-1:0] scan_addr;
  logic               scan_wrap;
  logic [ADDR_BITS:0] ram_addr;
  logic               ram_we;
  logic               ram_wdata;
  logic               ram_rdata;
  logic               out_valid_r;
  res_t               out_res_r;

  bbc_ctrl #(.ADDR_BITS(ADDR_BITS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (opcode_t'(in_tuser[0])),
    .in_order   (in_tdata[2:0]),
    .in_addr    (in_tdata[8:3]),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .k          (k),
    .blk_addr   (blk_addr),
    .use_buddy  (use_buddy),
    .map_idx    (map_idx),
    .merged_addr(merged_addr),
    .scan_addr  (scan_addr),
    .scan_wrap  (scan_wrap),
    .ram_addr   (ram_addr),
    .ram_we     (ram_we),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata)
  );

  bbc_index_unit #(.ADDR_BITS(ADDR_BITS)) u_index (
    .k          (k),
    .blk_addr   (blk_addr),
    .use_buddy  (use_buddy),
    .map_idx    (map_idx),
    .merged_addr(merged_addr),
    .scan_addr  (scan_addr),
    .scan_wrap  (scan_wrap)
  );

  bbc_map_ram #(.ADDR_BITS(ADDR_BITS)) u_map (
    .clk      (clk),
    .ram_addr (ram_addr),
    .ram_we   (ram_we),
    .ram_wdata(ram_wdata),
    .ram_rdata(ram_rdata)
  );

  // output register, refilled in the cycle it drains
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  // word packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.free_address, out_res_r.free_order};
  assign out_tuser  = {out_res_r.entry_valid, out_res_r.status};
  assign out_tlast  = out_res_r.is_last;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the buddy block coalescer: a directed table of free
// and list requests, then random traffic with fill sequences, all words
// checked against hand-written words or a bit-level free map predictor, with
// random bursts, gaps, output stalls and one long output hold-off
// ----------------------------------------------------------------------------
module tb_top import bbc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ABITS       = ADDR_BITS_DEF;
  localparam int SPACE       = 1 << ABITS;
  localparam int MAP_SLOTS   = (2 << ABITS) - 1;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_AT     = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int PRINT_MAX   = 20;

  typedef struct {
    opcode_t            op;
    logic [ORDER_W-1:0] ord;
    logic [ADDRF_W-1:0] adr;
    bit                 typed;
    res_t               want;
  } item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // block_order[2:0], block_address[8:3], zero
  logic [0:0]  in_tuser = '0;   // opcode[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // free_order[2:0], free_address[8:3], zero
  logic [2:0]  out_tuser;       // status[1:0], entry_valid[2]
  logic        out_tlast;

  bit    free_bits [0:MAP_SLOTS-1];
  res_t  predicted_words [$];
  res_t  awaited_words [$];
  item_t pending_items [$];
  int    accepted_cnt = 0;
  int    mismatch_cnt = 0;

  buddy_block_coalescer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // position of a block of order k in the level-packed free map
  function automatic int map_slot(input int k, input int a);
    return (2 * SPACE - ((2 * SPACE) >> k)) + (a >> k);
  endfunction

  // free-and-merge or sorted listing, words go to predicted_words
  function automatic void coalesce_or_list(input opcode_t op, input int ord, input int adr);
    int   k;
    int   a;
    int   sz;
    int   bud;
    res_t w;
    predicted_words = {};
    w = '{ST_OK, 1'b0, 3'd0, 6'd0, 1'b1};
    if (op == OP_FREE) begin
      k = ord;
      a = adr;
      if (k > ABITS || (a % (1 << k)) != 0 || (1 << k) > SPACE - a) begin
        w.status = ST_BAD;
      end else if (free_bits[map_slot(k, a)]) begin
        w.status = ST_DUP;
      end else begin
        free_bits[map_slot(k, a)] = 1'b1;
        while (k < ABITS) begin
          sz  = 1 << k;
          bud = (a % (2 * sz) == 0) ? a + sz : a - sz;
          if (!free_bits[map_slot(k, bud)]) break;
          free_bits[map_slot(k, bud)] = 1'b0;
          free_bits[map_slot(k, a)]   = 1'b0;
          if (bud < a) a = bud;
          k++;
          free_bits[map_slot(k, a)] = 1'b1;
        end
        w.entry_valid  = 1'b1;
        w.free_order   = ORDER_W'(k);
        w.free_address = ADDRF_W'(a);
      end
      predicted_words = {predicted_words, w};
    end else begin
      // listing walks orders low to high, addresses low to high, capped
      for (int o = 0; o <= ABITS; o++) begin
        for (int i = 0; i < (SPACE >> o); i++) begin
          if (predicted_words.size() < MAX_OUT && free_bits[map_slot(o, i << o)]) begin
            w = '{ST_OK, 1'b1, ORDER_W'(o), ADDRF_W'(i << o), 1'b0};
            predicted_words = {predicted_words, w};
          end
        end
      end
      if (predicted_words.size() == 0) begin
        w = '{ST_OK, 1'b0, 3'd0, 6'd0, 1'b1};
        predicted_words = {predicted_words, w};
      end else begin
        predicted_words[predicted_words.size() - 1].is_last = 1'b1;
      end
    end
  endfunction

  // queue one request, with a hand-written expected word where given
  task automatic push_item(input opcode_t op, input int ord, input int adr,
                           input bit typed = 1'b0, input status_t st = ST_OK,
                           input bit ev = 1'b0, input int fo = 0, input int fa = 0,
                           input bit lst = 1'b1);
    item_t it;
    it.op    = op;
    it.ord   = ORDER_W'(ord);
    it.adr   = ADDRF_W'(adr);
    it.typed = typed;
    it.want  = '{st, ev, ORDER_W'(fo), ADDRF_W'(fa), lst};
    pending_items = {pending_items, it};
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_cnt < PRINT_MAX)
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatch_cnt++;
  endtask

  // result side: compare each accepted word with the oldest expectation
  always @(posedge clk) begin : word_check
    res_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (awaited_words.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = awaited_words.pop_front();
        if (out_tuser[1:0] !== want.status)
          report_mismatch("status", out_tuser[1:0], want.status);
        if (out_tuser[2] !== want.entry_valid)
          report_mismatch("entry_valid", out_tuser[2], want.entry_valid);
        if (out_tdata[2:0] !== want.free_order)
          report_mismatch("free_order", out_tdata[2:0], want.free_order);
        if (out_tdata[8:3] !== want.free_address)
          report_mismatch("free_address", out_tdata[8:3], want.free_address);
        if (out_tlast !== want.is_last)
          report_mismatch("is_last", out_tlast, want.is_last);
      end
    end
  end

  // receiver stall pattern, with one long hold-off once traffic is flowing
  initial begin : rx_stall
    bit held;
    int mode;
    int mode_left;
    held = 1'b0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (!held && accepted_cnt >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 60);
      end
      mode_left--;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // stimulus, sender bursts and prediction at acceptance
  initial begin : drive
    item_t it;
    int    burst_left;
    int    k;
    int    n;
    int    off;
    int    pick;
    int    fills;

    // directed table, map starts empty
    push_item(OP_LIST, 0, 0,  1'b1, ST_OK,  1'b0, 0, 0,  1'b1);
    push_item(OP_FREE, 7, 0,  1'b1, ST_BAD, 1'b0, 0, 0,  1'b1);
    push_item(OP_FREE, 7, 63, 1'b1, ST_BAD, 1'b0, 0, 0,  1'b1);
    push_item(OP_FREE, 1, 1,  1'b1, ST_BAD, 1'b0, 0, 0,  1'b1);
    push_item(OP_FREE, 6, 32, 1'b1, ST_BAD, 1'b0, 0, 0,  1'b1);
    push_item(OP_FREE, 0, 63, 1'b1, ST_OK,  1'b1, 0, 63, 1'b1);
    push_item(OP_FREE, 0, 63, 1'b1, ST_DUP, 1'b0, 0, 0,  1'b1);
    push_item(OP_FREE, 0, 62);
    push_item(OP_FREE, 1, 60);
    // top order never merges, and overlap with smaller blocks is allowed
    push_item(OP_FREE, 6, 0,  1'b1, ST_OK,  1'b1, 6, 0,  1'b1);
    push_item(OP_FREE, 6, 0,  1'b1, ST_DUP, 1'b0, 0, 0,  1'b1);
    push_item(OP_LIST, 0, 0);
    // chain of merges up to order 5, then into the already free top block
    push_item(OP_FREE, 2, 56);
    push_item(OP_FREE, 3, 48);
    push_item(OP_FREE, 4, 32);
    push_item(OP_FREE, 5, 0);
    push_item(OP_LIST, 7, 63);
    push_item(OP_FREE, 0, 0);
    push_item(OP_FREE, 0, 1);
    push_item(OP_FREE, 5, 32);
    push_item(OP_LIST, 0, 0);

    // random part: fill sequences that overflow the listing, lists, noise
    // and mostly well-formed aligned frees
    fills = 0;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (fills == 0 || (pick < 3 && fills < 3)) begin
        fills++;
        for (int o = 0; o <= 4; o++) begin
          off = $urandom_range(0, (32 >> o) - 1);
          for (int i = 0; i < (32 >> o); i++)
            push_item(OP_FREE, o, ((i + off) % (32 >> o)) << (o + 1));
        end
        push_item(OP_LIST, $urandom_range(0, 7), $urandom_range(0, 63));
        n += 63;
      end else if (pick < 15) begin
        push_item(OP_LIST, $urandom_range(0, 7), $urandom_range(0, 63));
        n++;
      end else if (pick < 27) begin
        push_item(OP_FREE, $urandom_range(0, 7), $urandom_range(0, 63));
        n++;
      end else begin
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : $urandom_range(0, 2);
        push_item(OP_FREE, k, ($urandom_range(0, 63) >> k) << k);
        n++;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    burst_left = $urandom_range(1, 16);
    while (pending_items.size() != 0) begin
      it = pending_items.pop_front();
      in_tvalid <= 1'b1;
      in_tuser  <= it.op;
      in_tdata  <= {7'd0, it.adr, it.ord};
      @(posedge clk);
      while (in_tready !== 1'b1) @(posedge clk);

      coalesce_or_list(it.op, it.ord, it.adr);
      if (it.typed) begin
        awaited_words = {awaited_words, it.want};
      end else begin
        awaited_words = {awaited_words, predicted_words};
      end
      accepted_cnt <= accepted_cnt + 1;

      burst_left--;
      if (pending_items.size() == 0 || burst_left == 0) begin
        in_tvalid <= 1'b0;
        if (pending_items.size() != 0) begin
          repeat ($urandom_range(1, 6)) @(posedge clk);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 16);
        end
      end
    end

    // wait out the last words, then let the bench idle for DRAIN_CYCLES before the verdict
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
